/* src/btpc_pkg.sv */
// package for the barometric temperature / pressure compensation block
// payload, calibration and queue types, widths and register indexes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package btpc_pkg;

	localparam int REG_W = 48;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_TEMP       = 2'd0;
	localparam logic [IDX_W-1:0] REG_PRESS_LOW  = 2'd1;
	localparam logic [IDX_W-1:0] REG_PRESS_MID  = 2'd2;
	localparam logic [IDX_W-1:0] REG_PRESS_HIGH = 2'd3;

	localparam int QUEUE_DEPTH = 4;

	// |numerator| and |divisor| widths between front and back
	localparam int MAG_W = 67;
	localparam int DEN_W = 40;
	// numerator after scaling by 3125, must hold den shifted by QB
	localparam int NUM_W = 80;
	// quotient bits developed, one above the clamp
	localparam int QB = 37;
	localparam logic [QB-2:0] Q_MAX = '1;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] temperature_centi;
		logic [31:0]        pressure_q8;
		logic               status;
	} out_item_t;

	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} coef_t;

	// one request handed from front to back
	typedef struct packed {
		logic signed [23:0] temperature_centi;
		logic               status;
		logic               neg;
		logic [MAG_W-1:0]   mag;
		logic [DEN_W-1:0]   den;
	} qitem_t;

	// divider stage contents
	typedef struct packed {
		logic signed [23:0] temperature_centi;
		logic               status;
		logic               neg;
		logic               ovf;
		logic [DEN_W-1:0]   den;
		logic [NUM_W-1:0]   rem;
		logic [QB-1:0]      qv;
	} dv_t;

endpackage

`default_nettype wire

/* src/btpc_front.sv */
// front part: temperature compensation and the pressure numerator / divisor
// uses btpc_pkg; feeds btpc_queue
`timescale 1ns / 1ps
`default_nettype none

module btpc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire btpc_pkg::coef_t   coef,
	input  wire logic              in_valid,
	input  wire btpc_pkg::in_item_t in_data,
	output logic                   in_stall,
	output logic                   push,
	output btpc_pkg::qitem_t       push_data,
	input  wire logic              full
);

	logic [9:0] vld_q;
	logic       adv;

	logic [19:0] rt_s1, rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7;
	logic signed [34:0] ax_s2;
	logic signed [35:0] yy_s2;
	logic signed [23:0] a_s3;
	logic signed [39:0] bm_s3;
	logic signed [23:0] tf_s4;
	logic signed [23:0] tmp_s5, tmp_s6, tmp_s7, tmp_s8, tmp_s9;
	logic signed [23:0] v_s5;
	logic signed [47:0] vv_s6;
	logic signed [39:0] v5_s6, v2_s6, v5_s7, v2_s7;
	logic signed [63:0] w6_s7, u3_s7;
	logic signed [65:0] w_s8;
	logic signed [57:0] u_s8;
	logic [51:0]        nd_s8;
	logic signed [75:0] dp_s9;
	logic signed [66:0] diff_s9;
	btpc_pkg::qitem_t   out_s10;

	logic signed [18:0] x_c;
	logic signed [17:0] y_c;
	logic signed [23:0] ys_c;
	logic signed [25:0] sum_c;
	logic signed [26:0] t5_c;
	logic signed [23:0] v_c;
	logic signed [65:0] w_c;
	logic signed [57:0] u_c;
	logic [20:0]        pd_c;
	logic signed [58:0] base_c;
	logic signed [16:0] p1s_c;
	logic signed [42:0] d_c;
	logic signed [42:0] dabs_c;
	logic signed [66:0] mabs_c;

	assign adv      = !vld_q[9] || !full;
	assign in_stall = !adv;
	assign push     = vld_q[9] && !full;
	assign push_data = out_s10;

	always_comb begin
		x_c    = $signed({2'b00, rt_s1[19:3]}) - $signed({2'b00, coef.t1, 1'b0});
		y_c    = $signed({2'b00, rt_s1[19:4]}) - $signed({2'b00, coef.t1});
		ys_c   = yy_s2[35:12];
		sum_c  = a_s3 + $signed(bm_s3[39:14]);
		t5_c   = (tf_s4 <<< 2) + tf_s4 + 27'sd128;
		v_c    = tf_s4 - 24'sd128000;
		w_c    = w6_s7 + (v5_s7 <<< 17) + (coef.p4 <<< 35);
		u_c    = $signed(u3_s7[63:8]) + (v2_s7 <<< 12);
		pd_c   = 21'd1048576 - {1'b0, rp_s7};
		base_c = u_s8 + (59'sd1 <<< 47);
		p1s_c  = $signed({1'b0, coef.p1});
		d_c    = dp_s9[75:33];
		dabs_c = d_c[42] ? -d_c : d_c;
		mabs_c = diff_s9[66] ? -diff_s9 : diff_s9;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[8:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rt_s1 <= in_data.raw_temperature;
			rp_s1 <= in_data.raw_pressure;
			// temperature terms
			ax_s2 <= x_c * coef.t2;
			yy_s2 <= y_c * y_c;
			rp_s2 <= rp_s1;
			a_s3  <= ax_s2[34:11];
			bm_s3 <= ys_c * coef.t3;
			rp_s3 <= rp_s2;
			tf_s4 <= sum_c[23:0];
			rp_s4 <= rp_s3;
			tmp_s5 <= {{5{t5_c[26]}}, t5_c[26:8]};
			v_s5   <= v_c;
			rp_s5  <= rp_s4;
			// pressure polynomial
			vv_s6  <= v_s5 * v_s5;
			v5_s6  <= v_s5 * coef.p5;
			v2_s6  <= v_s5 * coef.p2;
			tmp_s6 <= tmp_s5;
			rp_s6  <= rp_s5;
			w6_s7  <= vv_s6 * coef.p6;
			u3_s7  <= vv_s6 * coef.p3;
			v5_s7  <= v5_s6;
			v2_s7  <= v2_s6;
			tmp_s7 <= tmp_s6;
			rp_s7  <= rp_s6;
			w_s8   <= w_c;
			u_s8   <= u_c;
			nd_s8  <= {pd_c, 31'b0};
			tmp_s8 <= tmp_s7;
			dp_s9   <= base_c * p1s_c;
			diff_s9 <= $signed({15'b0, nd_s8}) - w_s8;
			tmp_s9  <= tmp_s8;
			out_s10.temperature_centi <= tmp_s9;
			out_s10.status <= (d_c == '0);
			out_s10.neg    <= d_c[42] ^ diff_s9[66];
			out_s10.mag    <= mabs_c[btpc_pkg::MAG_W-1:0];
			out_s10.den    <= dabs_c[btpc_pkg::DEN_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* src/btpc_queue.sv */
// short request queue between front and back
// uses btpc_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none

module btpc_queue #(
	parameter int DEPTH = btpc_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire btpc_pkg::qitem_t push_data,
	output logic                  full,
	input  wire logic             pop,
	output btpc_pkg::qitem_t      pop_data,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	btpc_pkg::qitem_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

/* src/btpc_back.sv */
// back part: pipelined restoring divider and final pressure polynomial
// uses btpc_pkg; takes requests from btpc_queue
`timescale 1ns / 1ps
`default_nettype none

module btpc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire btpc_pkg::coef_t   coef,
	input  wire logic              empty,
	input  wire btpc_pkg::qitem_t  pop_data,
	output logic                   pop,
	output logic                   out_valid,
	output btpc_pkg::out_item_t    out_data,
	input  wire logic              out_stall
);

	localparam int QB = btpc_pkg::QB;
	localparam int NUM_W = btpc_pkg::NUM_W;
	localparam int NB = QB + 7;

	logic [NB-1:0] vld_q;
	logic          adv;

	btpc_pkg::qitem_t item_s1;
	btpc_pkg::dv_t    dv_s [QB+2];
	btpc_pkg::dv_t    dv1_c;
	logic signed [36:0] q_s41, q_s42, q_s43;
	logic signed [23:0] sh_s42;
	logic signed [39:0] p9s_s42;
	logic signed [52:0] p8q_s42, p8q_s43;
	logic signed [63:0] p9ss_s43;
	logic signed [23:0] tmp_s41, tmp_s42, tmp_s43;
	logic               st_s41, st_s42, st_s43;
	btpc_pkg::out_item_t out_s44;

	logic [QB-2:0]      qmag_c;
	logic signed [36:0] q_c;
	logic signed [23:0] sh_c;
	logic signed [41:0] sum_c;
	logic signed [41:0] p_c;
	logic [NUM_W-1:0]   top_c;

	assign adv       = !vld_q[NB-1] || !out_stall;
	assign pop       = adv && !empty;
	assign out_valid = vld_q[NB-1];
	assign out_data  = out_s44;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NB-2:0], pop};
		end
	end

	assign top_c = NUM_W'(dv_s[0].den) << QB;

	// quotient clamp check
	always_comb begin
		dv1_c     = dv_s[0];
		dv1_c.ovf = (dv_s[0].rem >= top_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= pop_data;
			dv_s[0].temperature_centi <= item_s1.temperature_centi;
			dv_s[0].status <= item_s1.status;
			dv_s[0].neg    <= item_s1.neg;
			dv_s[0].ovf    <= 1'b0;
			dv_s[0].den    <= item_s1.den;
			dv_s[0].rem    <= NUM_W'(item_s1.mag) * NUM_W'(3125);
			dv_s[0].qv     <= '0;
			dv_s[1]        <= dv1_c;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [NUM_W-1:0] trial;
		logic             ge;
		btpc_pkg::dv_t    nxt;
		assign trial = NUM_W'(dv_s[j+1].den) << (QB - 1 - j);
		assign ge    = !dv_s[j+1].ovf && (dv_s[j+1].rem >= trial);
		always_comb begin
			nxt     = dv_s[j+1];
			nxt.rem = ge ? dv_s[j+1].rem - trial : dv_s[j+1].rem;
			nxt.qv  = {dv_s[j+1].qv[QB-2:0], ge};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[j+2] <= nxt;
			end
		end
	end

	always_comb begin
		qmag_c = (dv_s[QB+1].ovf || dv_s[QB+1].qv[QB-1]) ? btpc_pkg::Q_MAX
			: dv_s[QB+1].qv[QB-2:0];
		q_c   = dv_s[QB+1].neg ? -$signed({1'b0, qmag_c}) : $signed({1'b0, qmag_c});
		sh_c  = q_s41[36:13];
		sum_c = q_s43 + $signed(p9ss_s43[63:25]) + $signed(p8q_s43[52:19]);
		p_c   = (sum_c >>> 8) + (coef.p7 <<< 4);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s41   <= q_c;
			tmp_s41 <= dv_s[QB+1].temperature_centi;
			st_s41  <= dv_s[QB+1].status;
			p9s_s42 <= coef.p9 * sh_c;
			p8q_s42 <= coef.p8 * q_s41;
			sh_s42  <= sh_c;
			q_s42   <= q_s41;
			tmp_s42 <= tmp_s41;
			st_s42  <= st_s41;
			p9ss_s43 <= p9s_s42 * sh_s42;
			p8q_s43  <= p8q_s42;
			q_s43    <= q_s42;
			tmp_s43  <= tmp_s42;
			st_s43   <= st_s42;
			out_s44.temperature_centi <= tmp_s43;
			out_s44.status <= st_s43;
			if (st_s43 || p_c < 0) begin
				out_s44.pressure_q8 <= '0;
			end else if (p_c > 42'sd4294967295) begin
				out_s44.pressure_q8 <= '1;
			end else begin
				out_s44.pressure_q8 <= p_c[31:0];
			end
		end
	end

endmodule

`default_nettype wire

/* src/baro_temp_pressure_compensation.sv */
// Barometric temperature and pressure compensation. When nothing stalls, one
// reading is accepted per clock and each gives one result. There are 10 front
// stages, the request queue and 44 back stages; 37 of them are the pressure
// divider, one bit per stage, whose pipeline sets throughput at one result per
// cycle. The user must write calibration registers through wr_en / wr_index /
// wr_data only while no reading is in flight; the block does not enforce this.
// top level: calibration registers, front, queue, back; uses btpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module baro_temp_pressure_compensation #(
	parameter int QUEUE_DEPTH = btpc_pkg::QUEUE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [btpc_pkg::IDX_W-1:0]    wr_index,
	input  wire logic [btpc_pkg::REG_W-1:0]    wr_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire btpc_pkg::in_item_t            in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output btpc_pkg::out_item_t                out_data
);

	logic [btpc_pkg::REG_W-1:0] temp_q, plow_q, pmid_q, phigh_q;
	btpc_pkg::coef_t  coef;
	btpc_pkg::qitem_t push_data, pop_data;
	logic push, pop, full, empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q  <= '0;
			plow_q  <= '0;
			pmid_q  <= '0;
			phigh_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				btpc_pkg::REG_TEMP:       temp_q  <= wr_data;
				btpc_pkg::REG_PRESS_LOW:  plow_q  <= wr_data;
				btpc_pkg::REG_PRESS_MID:  pmid_q  <= wr_data;
				btpc_pkg::REG_PRESS_HIGH: phigh_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		coef.t1 = temp_q[15:0];
		coef.t2 = temp_q[31:16];
		coef.t3 = temp_q[47:32];
		coef.p1 = plow_q[15:0];
		coef.p2 = plow_q[31:16];
		coef.p3 = plow_q[47:32];
		coef.p4 = pmid_q[15:0];
		coef.p5 = pmid_q[31:16];
		coef.p6 = pmid_q[47:32];
		coef.p7 = phigh_q[15:0];
		coef.p8 = phigh_q[31:16];
		coef.p9 = phigh_q[47:32];
	end

	btpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_stall  (in_stall),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	btpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	btpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.empty     (empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_stall (out_stall)
	);

endmodule

`default_nettype wire

/* src/btpc_check.sv */
// port-level checker for the compensation block, bound to the top level
// uses btpc_pkg for the payload types
`timescale 1ns / 1ps
`default_nettype none

module btpc_check (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire btpc_pkg::out_item_t out_data
);

	// requests in flight, seen from the ports
	logic [7:0] cnt_q;
	logic in_acc, out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && !out_acc) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 8'd0)
		else $error("result without a pending request");

	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |-> out_data.pressure_q8 == 32'd0)
		else $error("zero divisor with nonzero pressure");

endmodule

bind baro_temp_pressure_compensation btpc_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
